// File: rtl/fsps_pkg.sv
// Package for the four-sum pair search: widths, constants and shared types.
package fsps_pkg;

  localparam int MaxN = 64;
  localparam int ValueW = 32;
  localparam int TargetW = 34;
  localparam int IndexW = 7;

  // Sequencer states, one-hot
  typedef enum logic [6:0] {
    ST_LOAD  = 7'b0000001,
    ST_GEN   = 7'b0000010,
    ST_MREAD = 7'b0000100,
    ST_MCMP  = 7'b0001000,
    ST_SREAD = 7'b0010000,
    ST_SCMP  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

endpackage

// File: rtl/fsps_if.sv
// Valid/ready channel interfaces for the four-sum pair search.
interface fsps_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic        last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface fsps_out_if;
  logic       valid;
  logic       ready;
  logic       found;
  logic [6:0] first_index;
  logic [6:0] second_index;
  logic [6:0] third_index;
  logic [6:0] fourth_index;
  logic       overflowed;
  modport source (output valid, output found, output first_index, output second_index,
                  output third_index, output fourth_index, output overflowed, input ready);
  modport sink (input valid, input found, input first_index, input second_index,
                input third_index, input fourth_index, input overflowed, output ready);
endinterface

interface fsps_cfg_if;
  logic        valid;
  logic        ready;
  logic [33:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/four_sum_pair_search.sv
// Four-sum search: value load, pair generation, stable merge sort, two-pointer search.
// Loading: one value per cycle, ready between sets, no output.
// After last: P = N(N-1)/2 pairs are generated, merge sorted and then searched,
// all through one pair-memory port pair.
// Result waits in an output register until transferred; then the next set loads.
// Synchronous active-high reset clears count, overflow flag, target and sequencer state.
module four_sum_pair_search #(
  parameter int MAX_N = fsps_pkg::MaxN
) (
  input  logic clk,
  input  logic rst,
  fsps_in_if.sink   in_ch,
  fsps_out_if.source out_ch,
  fsps_cfg_if.sink  cfg
);
  import fsps_pkg::*;

  localparam int NP = MAX_N * (MAX_N - 1) / 2;
  localparam int IW = $clog2(MAX_N);
  localparam int CW = $clog2(MAX_N + 1);
  localparam int PW = $clog2(NP + 1);
  localparam int AW = $clog2(NP);
  localparam int SW = ValueW + 1;
  localparam int EW = SW + 2 * IW;

  typedef struct packed {
    logic [SW-1:0] sum;
    logic [IW-1:0] a;
    logic [IW-1:0] b;
  } pair_t;

  // Storage: value memory and two pair banks (ping-pong for the merge passes)
  logic [ValueW-1:0] vmem [MAX_N];
  pair_t pmem0 [NP];
  pair_t pmem1 [NP];

  state_t state;
  logic [TargetW-1:0] target;
  logic [CW-1:0] count;
  logic ovf;
  logic bank;            // bank holding current sorted data
  logic [IW-1:0] gi, gj;
  logic [PW-1:0] np, wr_ptr;
  logic [PW-1:0] width, left, pa, pb, mid, fin;
  logic [AW-1:0] rda, rdb;
  pair_t qa, qb;
  logic [PW-1:0] lo, hi;
  logic [ValueW-1:0] va, vb;
  logic gen_ph;          // 0: read values, 1: write pair

  logic wr_en;
  logic [AW-1:0] wr_addr;
  pair_t wr_data;
  logic wr_bank;

  logic res_found;
  logic [IndexW-1:0] r1, r2, r3, r4;
  logic res_ovf;

  assign in_ch.ready = (state == ST_LOAD);
  assign cfg.ready   = (state == ST_LOAD);
  assign out_ch.valid = (state == ST_OUT);
  assign out_ch.found = res_found;
  assign out_ch.first_index = r1;
  assign out_ch.second_index = r2;
  assign out_ch.third_index = r3;
  assign out_ch.fourth_index = r4;
  assign out_ch.overflowed = res_ovf;

  // Shared comparator and 34-bit adder
  logic [TargetW-1:0] ssum;
  logic take_b;
  logic a_ok, b_ok;
  assign ssum = TargetW'(qa.sum) + TargetW'(qb.sum);
  assign a_ok = pa < mid;
  assign b_ok = pb < fin;
  assign take_b = b_ok && (!a_ok || (qb.sum < qa.sum));

  // Memories
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && (count < CW'(MAX_N)))
      vmem[count[IW-1:0]] <= in_ch.value;
    va <= vmem[gi];
    vb <= vmem[gj];
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_bank) pmem0[wr_addr] <= wr_data;
    if (wr_en && wr_bank)  pmem1[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    qa <= bank ? pmem1[rda] : pmem0[rda];
    qb <= bank ? pmem1[rdb] : pmem0[rdb];
  end

  // Write port select
  always_comb begin
    wr_en = 1'b0;
    wr_bank = 1'b0;
    wr_addr = wr_ptr[AW-1:0];
    wr_data = take_b ? qb : qa;
    if (state == ST_GEN && gen_ph) begin
      wr_en = 1'b1;
      wr_data = '{sum: SW'(va) + SW'(vb), a: gi, b: gj};
    end else if (state == ST_MCMP) begin
      wr_en = 1'b1;
      wr_bank = !bank;
    end
  end

  // Read addresses
  always_comb begin
    if (state == ST_SREAD || state == ST_SCMP) begin
      rda = lo[AW-1:0];
      rdb = hi[AW-1:0];
    end else begin
      rda = pa[AW-1:0];
      rdb = pb[AW-1:0];
    end
  end

  // Sequencer
  logic [PW:0] l2, m2, e2;
  always_comb begin
    l2 = (PW+1)'(left) + (PW+1)'(width) + (PW+1)'(width);
    m2 = ((PW+1)'(l2) + (PW+1)'(width) > (PW+1)'(np)) ? (PW+1)'(np)
         : (PW+1)'(l2) + (PW+1)'(width);
    e2 = ((PW+1)'(l2) + (PW+1)'(width) + (PW+1)'(width) > (PW+1)'(np)) ? (PW+1)'(np)
         : (PW+1)'(l2) + (PW+1)'(width) + (PW+1)'(width);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      target <= '0;
      count <= '0;
      ovf <= 1'b0;
      bank <= 1'b0;
      gen_ph <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (cfg.valid) target <= cfg.data;
          if (in_ch.valid) begin
            // hold at capacity; extra values only raise the overflow flag
            if (count < CW'(MAX_N)) count <= count + 1'b1;
            else ovf <= 1'b1;
            if (in_ch.last) begin
              gi <= '0;
              gj <= IW'(1);
              gen_ph <= 1'b0;
              wr_ptr <= '0;
              bank <= 1'b0;
              lo <= '0;
              hi <= '0;
              // a single value forms no pair
              if (((count < CW'(MAX_N)) ? count + 1'b1 : count) < CW'(2))
                state <= ST_SREAD;
              else
                state <= ST_GEN;
            end
          end
        end
        ST_GEN: begin
          if (!gen_ph) gen_ph <= 1'b1;
          else begin
            gen_ph <= 1'b0;
            wr_ptr <= wr_ptr + 1'b1;
            if (CW'(gj) + 1'b1 < count) gj <= gj + 1'b1;
            else if (CW'(gi) + CW'(2) < count) begin
              gi <= gi + 1'b1;
              gj <= gi + IW'(2);
            end else begin
              np <= wr_ptr + 1'b1;
              width <= PW'(1);
              left <= '0;
              pa <= '0;
              pb <= PW'(1);
              mid <= PW'(1);
              fin <= (wr_ptr + 1'b1 > PW'(2)) ? PW'(2) : wr_ptr + 1'b1;
              wr_ptr <= '0;
              if (wr_ptr + 1'b1 > PW'(1)) state <= ST_MREAD;
              else begin
                lo <= '0;
                hi <= wr_ptr;
                state <= ST_SREAD;
              end
            end
          end
        end
        ST_MREAD: state <= ST_MCMP;
        ST_MCMP: begin
          if (take_b) pb <= pb + 1'b1; else pa <= pa + 1'b1;
          wr_ptr <= wr_ptr + 1'b1;
          state <= ST_MREAD;
          if (wr_ptr + 1'b1 == fin) begin
            // run done; next run or next pass
            if (l2 < (PW+1)'(np)) begin
              left <= l2[PW-1:0];
              pa <= l2[PW-1:0];
              pb <= m2[PW-1:0];
              mid <= m2[PW-1:0];
              fin <= e2[PW-1:0];
            end else begin
              bank <= !bank;
              wr_ptr <= '0;
              if ((PW+1)'(width) + (PW+1)'(width) < (PW+1)'(np)) begin
                width <= width + width;
                left <= '0;
                pa <= '0;
                pb <= ((PW+1)'(width) + (PW+1)'(width) > (PW+1)'(np)) ? np : width + width;
                mid <= ((PW+1)'(width) + (PW+1)'(width) > (PW+1)'(np)) ? np : width + width;
                fin <= ((PW+2)'(width) * (PW+2)'(4) > (PW+2)'(np)) ? np : PW'(4) * width;
              end else begin
                lo <= '0;
                hi <= np - 1'b1;
                state <= ST_SREAD;
              end
            end
          end
        end
        ST_SREAD: begin
          if (lo < hi) state <= ST_SCMP;
          else begin
            res_found <= 1'b0;
            {r1, r2, r3, r4} <= '0;
            res_ovf <= ovf;
            state <= ST_OUT;
          end
        end
        ST_SCMP: begin
          state <= ST_SREAD;
          if (ssum > target) hi <= hi - 1'b1;
          else if (ssum < target) lo <= lo + 1'b1;
          else if (qa.a != qb.a && qa.a != qb.b && qa.b != qb.a && qa.b != qb.b) begin
            res_found <= 1'b1;
            r1 <= IndexW'(qa.a) + 1'b1;
            r2 <= IndexW'(qa.b) + 1'b1;
            r3 <= IndexW'(qb.a) + 1'b1;
            r4 <= IndexW'(qb.b) + 1'b1;
            res_ovf <= ovf;
            state <= ST_OUT;
          end else lo <= lo + 1'b1;
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            count <= '0;
            ovf <= 1'b0;
            state <= ST_LOAD;
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_N))
    else $error("count beyond capacity");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(r1) && $stable(res_found))
    else $error("result changed while stalled");
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !res_found |-> r1 == '0 && r4 == '0)
    else $error("indices nonzero on miss");
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid))
    else $error("load during result");
`endif

endmodule
